// ===== rtl/core/gsa_pkg.sv =====
`default_nettype none
package gsa_pkg;

    localparam int MAX_PAGES_DEF = 8;
    localparam int MAX_SLOTS_DEF = 256;

    // Fixed field widths of the stream payload.
    localparam int OP_W    = 2;
    localparam int PAGE_W  = 3;
    localparam int SLOT_W  = 8;
    localparam int GEN_W   = 16;
    localparam int STAT_W  = 2;
    localparam int CFG_W   = 9;
    localparam logic [CFG_W-1:0] SPP_RESET = 9'd256;

    // Request queue between front and back.
    localparam int QDEPTH = 2;
    localparam int QAW    = 1;
    localparam int QCW    = 2;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID   = 2'd1;
    localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd2;

    typedef enum logic [1:0] {
        K_ALLOC,
        K_FREE,
        K_CHECK,
        K_BAD
    } kind_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_STACK,
        B_GEN,
        B_DONE
    } back_state_t;

    typedef struct packed {
        kind_t              kind;
        logic               slot_ok;
        logic [PAGE_W-1:0]  page;
        logic [SLOT_W-1:0]  slot;
        logic [GEN_W-1:0]   gen;
    } req_t;

endpackage
`default_nettype wire

// ===== rtl/core/generational_slot_allocator_top.sv =====
// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid/s_tready    tuser: op; tdata: page, slot, generation
// m_        out  m_tvalid/m_tready    tuser: status; tdata: page, slot, generation
// cfg_      in   cfg_we (no wait)     cfg_wdata: slots_per_page
//
// From the queue head to the output register an item goes through these steps:
// allocate walks free stack read, generation read-modify-write and result load;
// free/check skip the stack read; rejects go straight to the result.
// The single read port of each slot memory makes these steps sequential.
// Reset and every config write start a clearing pass over all MAX_PAGES*MAX_SLOTS
// entries (2048 by default) of the generation store; s_tready is low meanwhile.
// A two-beat queue keeps accepting, until full, while the back end or the output stalls.
`default_nettype none
module generational_slot_allocator_top #(
    parameter int MAX_PAGES = gsa_pkg::MAX_PAGES_DEF,
    parameter int MAX_SLOTS = gsa_pkg::MAX_SLOTS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // slots_per_page
    input  wire logic                       cfg_we,
    input  wire logic [gsa_pkg::CFG_W-1:0]  cfg_wdata,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // [1:0] op
    input  wire logic [gsa_pkg::OP_W-1:0]   s_tuser,
    // [2:0] page, [10:3] slot, [26:11] generation, [31:27] zero
    input  wire logic [31:0]                s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // [1:0] status
    output logic [gsa_pkg::STAT_W-1:0]      m_tuser,
    // [2:0] out_page, [10:3] out_slot, [26:11] out_generation, [31:27] zero
    output logic [31:0]                     m_tdata
);

    localparam int CW = $clog2(MAX_SLOTS + 1);

    logic           q_valid;
    logic           q_ready;
    gsa_pkg::req_t  q_item;
    logic           clearing;
    logic [CW-1:0]  n_slots;

    // Front: classify beats and queue them.
    gsa_front #(.MAX_SLOTS(MAX_SLOTS)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .n_slots  (n_slots),
        .clearing (clearing),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_ready  (q_ready)
    );

    // Back: page scan, slot memories, result register.
    gsa_back #(.MAX_PAGES(MAX_PAGES), .MAX_SLOTS(MAX_SLOTS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_ready   (q_ready),
        .clearing  (clearing),
        .n_slots   (n_slots),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire

// ===== rtl/core/gsa_ram.sv =====
`default_nettype none
module gsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/gsa_front.sv =====
`default_nettype none
module gsa_front #(
    parameter int MAX_SLOTS = gsa_pkg::MAX_SLOTS_DEF,
    localparam int CW = $clog2(MAX_SLOTS + 1)
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [gsa_pkg::OP_W-1:0]   s_tuser,
    input  wire logic [31:0]                s_tdata,
    input  wire logic [CW-1:0]              n_slots,
    input  wire logic                       clearing,
    output logic                            q_valid,
    output gsa_pkg::req_t                   q_item,
    input  wire logic                       q_ready
);

    gsa_pkg::req_t                 ent_reg [gsa_pkg::QDEPTH];
    logic [gsa_pkg::QAW-1:0]       wr_ptr_reg;
    logic [gsa_pkg::QAW-1:0]       rd_ptr_reg;
    logic [gsa_pkg::QCW-1:0]       cnt_reg;
    gsa_pkg::req_t                 cls;
    logic                          push;
    logic                          pop;

    // Classify the beat: decode op and range-check the slot.
    always_comb begin
        cls.page    = s_tdata[2:0];
        cls.slot    = s_tdata[10:3];
        cls.gen     = s_tdata[26:11];
        cls.slot_ok = 16'(cls.slot) < 16'(n_slots);
        case (s_tuser)
            gsa_pkg::OP_ALLOC: cls.kind = gsa_pkg::K_ALLOC;
            gsa_pkg::OP_FREE:  cls.kind = gsa_pkg::K_FREE;
            gsa_pkg::OP_CHECK: cls.kind = gsa_pkg::K_CHECK;
            default:           cls.kind = gsa_pkg::K_BAD;
        endcase
    end

    assign s_tready = (cnt_reg != gsa_pkg::QCW'(gsa_pkg::QDEPTH)) && !clearing;
    assign q_valid  = cnt_reg != '0;
    assign q_item   = ent_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= cls;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/gsa_back.sv =====
`default_nettype none
module gsa_back #(
    parameter int MAX_PAGES = gsa_pkg::MAX_PAGES_DEF,
    parameter int MAX_SLOTS = gsa_pkg::MAX_SLOTS_DEF,
    localparam int CW = $clog2(MAX_SLOTS + 1)
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_we,
    input  wire logic [gsa_pkg::CFG_W-1:0]  cfg_wdata,
    input  wire logic                       q_valid,
    input  wire gsa_pkg::req_t              q_item,
    output logic                            q_ready,
    output logic                            clearing,
    output logic [CW-1:0]                   n_slots,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [gsa_pkg::STAT_W-1:0]      m_tuser,
    output logic [31:0]                     m_tdata
);

    localparam int DEPTH = MAX_PAGES * MAX_SLOTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int SW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int PCW   = $clog2(MAX_PAGES + 1);
    localparam int GW    = gsa_pkg::GEN_W;

    function automatic logic [CW-1:0] clamp_slots(input logic [gsa_pkg::CFG_W-1:0] v);
        logic [CW-1:0] r;
        if (v == '0) begin
            r = CW'(1);
        end else if (16'(v) > 16'(MAX_SLOTS)) begin
            r = CW'(MAX_SLOTS);
        end else begin
            r = CW'(v);
        end
        return r;
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [PW-1:0] p, input logic [SW-1:0] s);
        return AW'(p) * AW'(MAX_SLOTS) + AW'(s);
    endfunction

    localparam logic [CW-1:0] N_RESET = clamp_slots(gsa_pkg::SPP_RESET);

    gsa_pkg::back_state_t           state_reg, state_next;
    logic [AW-1:0]                  clr_cnt_reg;
    logic [gsa_pkg::CFG_W-1:0]      spp_reg;
    logic [CW-1:0]                  cnt_reg [MAX_PAGES];
    logic [CW-1:0]                  wm_reg  [MAX_PAGES];
    logic [PCW-1:0]                 pages_reg;
    gsa_pkg::kind_t                 kind_reg;
    logic [PW-1:0]                  pg_reg;
    logic [SW-1:0]                  slot_reg;
    logic [SW-1:0]                  top_reg;
    logic                           ident_reg;
    logic [GW-1:0]                  gen_reg;
    logic [gsa_pkg::STAT_W-1:0]     res_status_reg;
    logic [gsa_pkg::PAGE_W-1:0]     res_page_reg;
    logic [gsa_pkg::SLOT_W-1:0]     res_slot_reg;
    logic [GW-1:0]                  res_gen_reg;
    logic                           m_valid_reg;
    logic [gsa_pkg::STAT_W-1:0]     m_status_reg;
    logic [gsa_pkg::PAGE_W-1:0]     m_page_reg;
    logic [gsa_pkg::SLOT_W-1:0]     m_slot_reg;
    logic [GW-1:0]                  m_gen_reg;

    logic                           found;
    logic [PW-1:0]                  found_idx;
    logic                           alloc_go;
    logic [PW-1:0]                  alloc_pg;
    logic [CW-1:0]                  alloc_cnt;
    logic [CW-1:0]                  alloc_wm;
    logic [CW-1:0]                  alloc_top_c;
    logic [SW-1:0]                  alloc_top;
    logic [PW-1:0]                  in_pg;
    logic [SW-1:0]                  in_slot;
    logic                           in_range;
    logic [SW-1:0]                  stack_slot;
    logic [GW-1:0]                  gen_inc;
    logic                           gen_match;
    logic                           push_ok;
    logic                           out_free;
    logic [CW-1:0]                  n_init;

    logic                           stack_we, stack_re, gen_we, gen_re;
    logic [AW-1:0]                  stack_waddr, stack_raddr, gen_waddr, gen_raddr;
    logic [SW-1:0]                  stack_wdata, stack_rdata;
    logic [GW:0]                    gen_wdata, gen_rdata;

    gsa_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_stack_ram (
        .aclk(aclk), .we(stack_we), .waddr(stack_waddr), .wdata(stack_wdata),
        .re(stack_re), .raddr(stack_raddr), .rdata(stack_rdata)
    );

    // Generation store: occupied flag on top of the generation.
    gsa_ram #(.WIDTH(GW + 1), .DEPTH(DEPTH)) u_gen_ram (
        .aclk(aclk), .we(gen_we), .waddr(gen_waddr), .wdata(gen_wdata),
        .re(gen_re), .raddr(gen_raddr), .rdata(gen_rdata)
    );

    assign n_slots  = clamp_slots(spp_reg);
    assign clearing = state_reg == gsa_pkg::B_CLEAR;
    assign out_free = !m_valid_reg || m_tready;
    assign n_init   = !aresetn ? N_RESET : clamp_slots(cfg_wdata);

    // Lowest created page with a free slot.
    always_comb begin
        found     = 1'b0;
        found_idx = '0;
        for (int i = 0; i < MAX_PAGES; i++) begin
            if (!found && (PCW'(i) < pages_reg) && (cnt_reg[i] != '0)) begin
                found     = 1'b1;
                found_idx = PW'(i);
            end
        end
    end

    assign alloc_go    = found || (pages_reg < PCW'(MAX_PAGES));
    assign alloc_pg    = found ? found_idx : PW'(pages_reg);
    assign alloc_cnt   = found ? cnt_reg[found_idx] : n_slots;
    assign alloc_wm    = found ? wm_reg[found_idx] : n_slots;
    assign alloc_top_c = alloc_cnt - CW'(1);
    assign alloc_top   = SW'(alloc_top_c);
    assign in_pg       = PW'(q_item.page);
    assign in_slot     = SW'(q_item.slot);
    assign in_range    = q_item.slot_ok && (8'(q_item.page) < 8'(pages_reg));
    // Below the watermark the stack still holds its fill pattern.
    assign stack_slot  = ident_reg ? top_reg : stack_rdata;
    assign gen_inc     = gen_rdata[GW-1:0] + GW'(1);
    assign gen_match   = gen_rdata[GW] && (gen_rdata[GW-1:0] == gen_reg);
    assign push_ok     = 16'(cnt_reg[pg_reg]) < 16'(MAX_SLOTS);

    always_comb begin
        state_next  = state_reg;
        q_ready     = 1'b0;
        stack_we    = 1'b0;
        stack_waddr = '0;
        stack_wdata = '0;
        stack_re    = 1'b0;
        stack_raddr = '0;
        gen_we      = 1'b0;
        gen_waddr   = '0;
        gen_wdata   = '0;
        gen_re      = 1'b0;
        gen_raddr   = '0;
        case (state_reg)
            gsa_pkg::B_CLEAR: begin
                gen_we    = 1'b1;
                gen_waddr = clr_cnt_reg;
                if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                    state_next = gsa_pkg::B_IDLE;
                end
            end
            gsa_pkg::B_IDLE: begin
                if (q_valid) begin
                    q_ready    = 1'b1;
                    state_next = gsa_pkg::B_DONE;
                    case (q_item.kind)
                        gsa_pkg::K_ALLOC: begin
                            if (alloc_go) begin
                                stack_re    = 1'b1;
                                stack_raddr = addr_of(alloc_pg, alloc_top);
                                state_next  = gsa_pkg::B_STACK;
                            end
                        end
                        gsa_pkg::K_FREE, gsa_pkg::K_CHECK: begin
                            if (in_range) begin
                                gen_re     = 1'b1;
                                gen_raddr  = addr_of(in_pg, in_slot);
                                state_next = gsa_pkg::B_GEN;
                            end
                        end
                        default: begin
                            state_next = gsa_pkg::B_DONE;
                        end
                    endcase
                end
            end
            gsa_pkg::B_STACK: begin
                gen_re     = 1'b1;
                gen_raddr  = addr_of(pg_reg, stack_slot);
                state_next = gsa_pkg::B_GEN;
            end
            gsa_pkg::B_GEN: begin
                state_next = gsa_pkg::B_DONE;
                case (kind_reg)
                    gsa_pkg::K_ALLOC: begin
                        gen_we    = 1'b1;
                        gen_waddr = addr_of(pg_reg, slot_reg);
                        gen_wdata = {1'b1, gen_inc};
                    end
                    gsa_pkg::K_FREE: begin
                        if (gen_match) begin
                            gen_we    = 1'b1;
                            gen_waddr = addr_of(pg_reg, slot_reg);
                            gen_wdata = {1'b0, gen_inc};
                            if (push_ok) begin
                                stack_we    = 1'b1;
                                stack_waddr = addr_of(pg_reg, SW'(cnt_reg[pg_reg]));
                                stack_wdata = slot_reg;
                            end
                        end
                    end
                    default: begin
                        gen_we = 1'b0;
                    end
                endcase
            end
            gsa_pkg::B_DONE: begin
                if (out_free) begin
                    state_next = gsa_pkg::B_IDLE;
                end
            end
            default: begin
                state_next = gsa_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we) begin
            state_reg <= gsa_pkg::B_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we) begin
            clr_cnt_reg <= '0;
            // Page 0 starts full, the rest empty.
            for (int i = 0; i < MAX_PAGES; i++) begin
                cnt_reg[i] <= (i == 0) ? n_init : '0;
                wm_reg[i]  <= (i == 0) ? n_init : '0;
            end
            pages_reg <= PCW'(1);
            spp_reg   <= !aresetn ? gsa_pkg::SPP_RESET : cfg_wdata;
        end else begin
            case (state_reg)
                gsa_pkg::B_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                end
                gsa_pkg::B_IDLE: begin
                    if (q_valid) begin
                        kind_reg       <= q_item.kind;
                        res_status_reg <= (q_item.kind == gsa_pkg::K_ALLOC && !alloc_go) ?
                                          gsa_pkg::ST_EXHAUSTED : gsa_pkg::ST_INVALID;
                        res_page_reg   <= '0;
                        res_slot_reg   <= '0;
                        res_gen_reg    <= '0;
                        case (q_item.kind)
                            gsa_pkg::K_ALLOC: begin
                                if (alloc_go) begin
                                    pg_reg             <= alloc_pg;
                                    top_reg            <= alloc_top;
                                    ident_reg          <= alloc_top_c < alloc_wm;
                                    cnt_reg[alloc_pg]  <= alloc_top_c;
                                    wm_reg[alloc_pg]   <= (alloc_top_c < alloc_wm) ?
                                                          alloc_top_c : alloc_wm;
                                    if (!found) begin
                                        pages_reg <= pages_reg + PCW'(1);
                                    end
                                end
                            end
                            gsa_pkg::K_FREE, gsa_pkg::K_CHECK: begin
                                pg_reg   <= in_pg;
                                slot_reg <= in_slot;
                                gen_reg  <= q_item.gen;
                            end
                            default: begin
                                pg_reg <= pg_reg;
                            end
                        endcase
                    end
                end
                gsa_pkg::B_STACK: begin
                    slot_reg <= stack_slot;
                end
                gsa_pkg::B_GEN: begin
                    case (kind_reg)
                        gsa_pkg::K_ALLOC: begin
                            res_status_reg <= gsa_pkg::ST_OK;
                            res_page_reg   <= gsa_pkg::PAGE_W'(pg_reg);
                            res_slot_reg   <= gsa_pkg::SLOT_W'(slot_reg);
                            res_gen_reg    <= gen_inc;
                        end
                        gsa_pkg::K_FREE: begin
                            if (gen_match) begin
                                res_status_reg <= gsa_pkg::ST_OK;
                                if (push_ok) begin
                                    cnt_reg[pg_reg] <= cnt_reg[pg_reg] + CW'(1);
                                end
                            end
                        end
                        default: begin
                            if (gen_match) begin
                                res_status_reg <= gsa_pkg::ST_OK;
                            end
                        end
                    endcase
                end
                default: begin
                    clr_cnt_reg <= clr_cnt_reg;
                end
            endcase
        end
    end

    // Output register: load the finished result, drop it when taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == gsa_pkg::B_DONE && out_free) begin
            m_valid_reg  <= 1'b1;
            m_status_reg <= res_status_reg;
            m_page_reg   <= res_page_reg;
            m_slot_reg   <= res_slot_reg;
            m_gen_reg    <= res_gen_reg;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {5'd0, m_gen_reg, m_slot_reg, m_page_reg};

endmodule
`default_nettype wire

// ===== rtl/core/gsa_checker.sv =====
`default_nettype none
module gsa_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        cfg_we,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [1:0]  m_tuser,
    input wire logic [31:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != gsa_pkg::ST_OK) |-> m_tdata == 32'd0)
        else $error("rejected result carries a handle");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == gsa_pkg::ST_OK) || (m_tuser == gsa_pkg::ST_INVALID) ||
                     (m_tuser == gsa_pkg::ST_EXHAUSTED))
        else $error("unknown status");

    a_reset_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_cfg_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !s_tready)
        else $error("input open during clearing pass");

endmodule

bind generational_slot_allocator_top gsa_checker u_gsa_checker (.*);
`default_nettype wire

// ===== dv/testbench.sv =====
`default_nettype none
// Model of the slot pool; predicts each response as requests are accepted.
class handle_pool_model;
    int unsigned spp;
    bit [7:0]  free_stack [8][256];
    int unsigned free_cnt [8];
    bit [15:0] gen_mem [8][256];
    bit        busy [8][256];
    int unsigned npages;
    bit [1:0]  exp_status [$];
    bit [26:0] exp_handle [$];
    int unsigned errors;

    function int unsigned eff();
        if (spp < 1) return 1;
        if (spp > 256) return 256;
        return spp;
    endfunction

    function void open_page(int unsigned p);
        for (int s = 0; s < eff(); s++) begin
            free_stack[p][s] = s[7:0];
            gen_mem[p][s] = 16'd0;
            busy[p][s] = 1'b0;
        end
        free_cnt[p] = eff();
    endfunction

    function void reinit(int unsigned v);
        spp = v;
        for (int p = 0; p < 8; p++) begin
            free_cnt[p] = 0;
            for (int s = 0; s < 256; s++) begin
                gen_mem[p][s] = 0;
                busy[p][s] = 0;
                free_stack[p][s] = 0;
            end
        end
        npages = 1;
        open_page(0);
    endfunction

    function bit handle_ok(bit [2:0] p, bit [7:0] s, bit [15:0] g);
        if (p >= npages) return 0;
        if (s >= eff()) return 0;
        if (!busy[p][s]) return 0;
        return gen_mem[p][s] == g;
    endfunction

    // Note an accepted request beat and queue its expected response.
    function void note_request(bit [1:0] op, bit [2:0] p, bit [7:0] s, bit [15:0] g);
        bit [1:0] st;
        bit [26:0] h;
        int unsigned pg, top;
        bit found;
        bit [7:0] sl;
        st = gsa_pkg::ST_INVALID;
        h = '0;
        found = 0;
        if (op == gsa_pkg::OP_ALLOC) begin
            for (pg = 0; pg < npages; pg++)
                if (free_cnt[pg] != 0) begin
                    found = 1;
                    break;
                end
            if (!found && npages < 8) begin
                pg = npages;
                open_page(pg);
                npages++;
                found = 1;
            end
            if (!found) begin
                st = gsa_pkg::ST_EXHAUSTED;
            end else begin
                top = free_cnt[pg] - 1;
                sl = free_stack[pg][top];
                free_cnt[pg] = top;
                gen_mem[pg][sl] = gen_mem[pg][sl] + 16'd1;
                busy[pg][sl] = 1;
                st = gsa_pkg::ST_OK;
                h = {gen_mem[pg][sl], sl, pg[2:0]};
            end
        end else if (op == gsa_pkg::OP_FREE) begin
            if (handle_ok(p, s, g)) begin
                busy[p][s] = 0;
                gen_mem[p][s] = gen_mem[p][s] + 16'd1;
                if (free_cnt[p] < 256) begin
                    free_stack[p][free_cnt[p]] = s;
                    free_cnt[p]++;
                end
                st = gsa_pkg::ST_OK;
            end
        end else if (op == gsa_pkg::OP_CHECK) begin
            if (handle_ok(p, s, g)) st = gsa_pkg::ST_OK;
        end
        exp_status = {exp_status, st};
        exp_handle = {exp_handle, h};
    endfunction

    // Compare one response beat with the oldest expectation.
    function void check_response(bit [1:0] st, bit [31:0] d);
        bit [1:0] es;
        bit [26:0] eh;
        if (exp_status.size() == 0) begin
            $display("%0t: unexpected response status=%0d data=%h", $time, st, d);
            errors++;
            return;
        end
        es = exp_status.pop_front();
        eh = exp_handle.pop_front();
        if (st !== es) begin
            $display("%0t: status expected %0d actual %0d", $time, es, st);
            errors++;
        end
        if (d !== {5'd0, eh}) begin
            $display("%0t: handle expected %h actual %h", $time, {5'd0, eh}, d);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [8:0]  cfg_wdata = '0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [1:0]  s_tuser = '0;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [1:0]  m_tuser;
    logic [31:0] m_tdata;

    handle_pool_model pool;
    // Up to 64 handles handed out by allocations, reused to build legal free/check beats.
    bit [26:0]   live [$];

    always #5 aclk = ~aclk;

    generational_slot_allocator_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata)
    );

    // Response side: random stall before each beat.
    initial begin
        int gap;
        pool = new();
        pool.reinit(256);
        forever begin
            gap = $urandom_range(0, 11);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            pool.check_response(m_tuser, m_tdata);
            if (live.size() < 64 && m_tuser == gsa_pkg::ST_OK && m_tdata != 0)
                live = {live, m_tdata[26:0]};
        end
    end

    // Send one request beat; hold tvalid until accepted.
    task automatic send_req(input bit [1:0] op, input bit [2:0] p, input bit [7:0] s,
                            input bit [15:0] g);
        int gap;
        gap = $urandom_range(0, 11);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'd0, g, s, p};
        do @(posedge aclk); while (s_tready !== 1'b1);
        pool.note_request(op, p, s, g);
    endtask

    // Wait for all responses, then write the pool size while idle.
    task automatic write_spp(input bit [8:0] v);
        s_tvalid <= 1'b0;
        while (pool.exp_status.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        pool.reinit(v);
        live.delete();
    endtask

    task automatic random_phase(input int n);
        bit [26:0] h;
        int k, r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                send_req(gsa_pkg::OP_ALLOC, 3'($urandom), 8'($urandom), 16'($urandom));
            end else if (r < 85 && live.size() != 0) begin
                // Reuse a live handle; occasionally corrupt its generation.
                k = $urandom_range(0, live.size() - 1);
                h = live[k];
                if ($urandom_range(0, 5) == 0) h[26:11] = 16'($urandom);
                if ($urandom_range(0, 1)) begin
                    send_req(gsa_pkg::OP_FREE, h[2:0], h[10:3], h[26:11]);
                    live.delete(k);
                end else begin
                    send_req(gsa_pkg::OP_CHECK, h[2:0], h[10:3], h[26:11]);
                end
            end else begin
                send_req(2'($urandom), 3'($urandom), 8'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: first allocation takes the top slot of page 0.
        send_req(gsa_pkg::OP_ALLOC, 3'd7, 8'hff, 16'hffff);
        send_req(gsa_pkg::OP_CHECK, 3'd0, 8'd255, 16'd1);
        send_req(gsa_pkg::OP_CHECK, 3'd0, 8'd255, 16'd2);    // wrong generation
        send_req(gsa_pkg::OP_CHECK, 3'd0, 8'd0, 16'd0);      // slot never allocated
        send_req(gsa_pkg::OP_FREE,  3'd1, 8'd0, 16'd0);      // page not yet created
        send_req(OP_UNKNOWN,        3'd0, 8'd255, 16'd1);    // unknown op
        send_req(gsa_pkg::OP_FREE,  3'd0, 8'd255, 16'd1);
        send_req(gsa_pkg::OP_FREE,  3'd0, 8'd255, 16'd2);    // double free
        send_req(gsa_pkg::OP_ALLOC, 3'd0, 8'd0, 16'd0);      // same slot, generation 3

        // One-slot pages: exhaust all eight.
        write_spp(9'd1);
        for (int i = 0; i < 9; i++) send_req(gsa_pkg::OP_ALLOC, 3'd0, 8'd0, 16'd0);
        send_req(gsa_pkg::OP_CHECK, 3'd0, 8'd1, 16'd1);      // slot beyond count
        write_spp(9'd0);                                     // behaves as one slot
        send_req(gsa_pkg::OP_ALLOC, 3'd0, 8'd0, 16'd0);
        send_req(gsa_pkg::OP_CHECK, 3'd0, 8'd0, 16'd1);
        write_spp(9'd511);                                   // clamps to full pages
        send_req(gsa_pkg::OP_ALLOC, 3'd0, 8'd0, 16'd0);

        write_spp(9'd1);
        send_req(gsa_pkg::OP_ALLOC, 3'd0, 8'd0, 16'd0);
        send_req(gsa_pkg::OP_CHECK, 3'd0, 8'd0, 16'd1);

        write_spp(9'd3);
        random_phase(120);
        write_spp(9'd2);
        random_phase(120);
        write_spp(9'd256);
        random_phase(130);

        s_tvalid <= 1'b0;
        while (pool.exp_status.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (pool.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/gsa_pkg.sv
rtl/core/gsa_ram.sv
rtl/core/gsa_front.sv
rtl/core/gsa_back.sv
rtl/core/generational_slot_allocator_top.sv
rtl/core/gsa_checker.sv
dv/testbench.sv
